>>> design/scc_pkg.sv
// Shared types and constants for the snooping coherent cache controller.
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;

  localparam logic [2:0] REQ_PRD   = 3'd0;
  localparam logic [2:0] REQ_PWR   = 3'd1;
  localparam logic [2:0] REQ_BRD   = 3'd2;
  localparam logic [2:0] REQ_BRDX  = 3'd3;
  localparam logic [2:0] REQ_BUPGR = 3'd4;
  localparam logic [2:0] REQ_BUPD  = 3'd5;
  // unused request codes, ignored apart from the lookup
  localparam logic [2:0] REQ_RSV6  = 3'd6;
  localparam logic [2:0] REQ_RSV7  = 3'd7;

  localparam logic [2:0] ST_I  = 3'd0;
  localparam logic [2:0] ST_S  = 3'd1;
  localparam logic [2:0] ST_E  = 3'd2;
  localparam logic [2:0] ST_M  = 3'd3;
  localparam logic [2:0] ST_SC = 3'd4;
  localparam logic [2:0] ST_SM = 3'd5;

  localparam logic [1:0] MODE_MSI    = 2'd0;
  localparam logic [1:0] MODE_MESI   = 2'd1;
  localparam logic [1:0] MODE_DRAGON = 2'd2;
  // unused mode, runs as MSI
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] addr;
    logic        other_copies;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic       issue_bus_rd;
    logic       issue_bus_rdx;
    logic       issue_bus_upgr;
    logic       issue_bus_update;
    logic       did_writeback;
    logic       did_flush;
    logic       did_intervention;
    logic       did_invalidation;
    logic [1:0] mem_transactions;
    logic       cache_transfer;
    logic [2:0] line_state;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request, start set read
    logic update;  // compute and write back the set
  } ctl_t;

  // next coherence state and result flags for one item
  function automatic rsp_t next_state(input logic [1:0] mode_raw, input logic [2:0] req,
                                      input logic oc, input logic hit,
                                      input logic [2:0] cur, input logic [2:0] vic);
    rsp_t r;
    logic [1:0] mode;
    logic wr;
    logic dirty;
    logic [2:0] st;
    begin
      r = '0;
      mode = (mode_raw == MODE_RSVD) ? MODE_MSI : mode_raw;
      wr = (req == REQ_PWR);
      st = cur;
      if (req == REQ_PRD || req == REQ_PWR) begin
        if (!hit) begin
          dirty = (vic == ST_M) || (mode == MODE_DRAGON && vic == ST_SM);
          r.mem_transactions = 2'd1;
          if (mode == MODE_MESI && oc) begin
            r.mem_transactions = 2'd0;
            r.cache_transfer = 1'b1;
          end
          if (dirty) begin
            r.did_writeback = 1'b1;
            r.mem_transactions = r.mem_transactions + 2'd1;
          end
          if (mode == MODE_MSI) begin
            st = wr ? ST_M : ST_S;
            r.issue_bus_rdx = wr;
            r.issue_bus_rd = !wr;
          end else if (mode == MODE_MESI) begin
            st = wr ? ST_M : (oc ? ST_S : ST_E);
            r.issue_bus_rdx = wr;
            r.issue_bus_rd = !wr;
          end else begin
            r.issue_bus_rd = 1'b1;
            if (oc) begin
              st = wr ? ST_SM : ST_SC;
              r.issue_bus_update = wr;
            end else begin
              st = wr ? ST_M : ST_E;
            end
          end
        end else begin
          r.hit = 1'b1;
          if (wr) begin
            if (mode == MODE_MSI) begin
              if (st == ST_S) begin
                st = ST_M; r.issue_bus_rdx = 1'b1; r.mem_transactions = 2'd1;
              end
            end else if (mode == MODE_MESI) begin
              if (st == ST_E) st = ST_M;
              else if (st == ST_S) begin st = ST_M; r.issue_bus_upgr = 1'b1; end
            end else begin
              if (st == ST_E) st = ST_M;
              else if (st == ST_SC || st == ST_SM) begin
                st = oc ? ST_SM : ST_M; r.issue_bus_update = 1'b1;
              end
            end
          end
        end
        r.line_state = st;
      end else if (hit) begin
        r.hit = 1'b1;
        if (req == REQ_BRD) begin
          if (mode == MODE_DRAGON) begin
            if (st == ST_M) begin st = ST_SM; r.did_intervention = 1'b1; end
            if (st == ST_E) begin st = ST_SC; r.did_intervention = 1'b1; end
            if (st == ST_SM) r.did_flush = 1'b1;
          end else begin
            if (st == ST_M) begin
              st = ST_S; r.did_flush = 1'b1; r.did_writeback = 1'b1;
              r.did_intervention = 1'b1; r.mem_transactions = 2'd1;
            end
            if (mode == MODE_MESI && st == ST_E) begin
              st = ST_S; r.did_intervention = 1'b1;
            end
          end
        end else if (req == REQ_BRDX && mode != MODE_DRAGON) begin
          if (st == ST_M) begin
            r.did_flush = 1'b1; r.did_writeback = 1'b1; r.mem_transactions = 2'd1;
          end
          if (mode == MODE_MSI || st == ST_M || st == ST_S || st == ST_E) begin
            r.did_invalidation = 1'b1; st = ST_I;
          end
        end else if (req == REQ_BUPGR && mode == MODE_MESI) begin
          if (st == ST_S) begin r.did_invalidation = 1'b1; st = ST_I; end
        end else if (req == REQ_BUPD && mode == MODE_DRAGON) begin
          if (st == ST_SM) st = ST_SC;
        end
        r.line_state = st;
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

>>> design/scc_datapath.sv
// Set storage (tags, states, LRU ranks) and per-item update logic.
`timescale 1ns / 1ps
`default_nettype none
module scc_datapath #(
  parameter int unsigned NUM_SETS    = 16,
  parameter int unsigned NUM_WAYS    = 8,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire scc_pkg::ctl_t ctl_i,
  input  wire scc_pkg::req_t req_i,
  input  wire logic [1:0]    mode_i,
  output scc_pkg::rsp_t      rsp_o
);
  localparam int unsigned OBITS = $clog2(BLOCK_BYTES);
  localparam int unsigned SBITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned SREAL = $clog2(NUM_SETS);
  localparam int unsigned TBITS = ADDR_BITS - OBITS - SREAL;
  localparam int unsigned WBITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned RBITS = $clog2(NUM_WAYS + 1);
  localparam int unsigned ABITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  // one memory word per set: all ways side by side
  typedef logic [NUM_WAYS-1:0][TBITS-1:0] tag_row_t;
  typedef logic [NUM_WAYS-1:0][2:0]       st_row_t;
  typedef logic [NUM_WAYS-1:0][RBITS-1:0] rk_row_t;

  tag_row_t tag_mem [NUM_SETS];
  st_row_t  st_mem  [NUM_SETS];
  rk_row_t  rk_mem  [NUM_SETS];
  logic [NUM_SETS-1:0] set_vld_q;

  tag_row_t tag_rd_q;
  st_row_t  st_rd_q;
  rk_row_t  rk_rd_q;
  logic     rd_vld_q;
  scc_pkg::req_t req_q;
  scc_pkg::rsp_t rsp_q;

  logic [ADDR_BITS-1:0] addr_full;
  logic [SBITS-1:0] set_idx, set_q_idx;
  logic [TBITS-1:0] tag_q;

  assign addr_full = ADDR_BITS'({{(64-ABITS){1'b0}}, req_i.addr[ABITS-1:0]});

  always_comb begin
    set_idx = '0;
    set_q_idx = '0;
    if (SREAL > 0) begin
      set_idx   = SBITS'(addr_full >> OBITS);
      set_q_idx = SBITS'(ADDR_BITS'({{(64-ABITS){1'b0}}, req_q.addr[ABITS-1:0]}) >> OBITS);
    end
    tag_q  = TBITS'(ADDR_BITS'({{(64-ABITS){1'b0}}, req_q.addr[ABITS-1:0]})
                    >> (OBITS + SREAL));
  end

  // lookup, victim choice and LRU update on the registered set
  st_row_t st_eff;
  rk_row_t rk_eff, rk_new;
  st_row_t st_new;
  tag_row_t tag_new;
  logic hit, proc;
  logic [WBITS-1:0] hw, vw, tw;
  logic [RBITS-1:0] best, r;
  scc_pkg::rsp_t res;

  always_comb begin
    st_eff = rd_vld_q ? st_rd_q : '0;
    rk_eff = rd_vld_q ? rk_rd_q : '0;
    hit = 1'b0; hw = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (st_eff[w] != scc_pkg::ST_I && tag_rd_q[w] == tag_q) begin
        hit = 1'b1; hw = WBITS'(w);
      end
    end
    vw = '0; best = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rk_eff[w] >= best) begin best = rk_eff[w]; vw = WBITS'(w); end
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (st_eff[w] == scc_pkg::ST_I) vw = WBITS'(w);
    end
    proc = (req_q.req_type == scc_pkg::REQ_PRD) || (req_q.req_type == scc_pkg::REQ_PWR);
    res = scc_pkg::next_state(mode_i, req_q.req_type, req_q.other_copies, hit,
                              st_eff[hw], st_eff[vw]);
    tw = hit ? hw : vw;
    st_new = st_eff; rk_new = rk_eff; tag_new = tag_rd_q;
    if (proc) begin
      r = (st_eff[tw] != scc_pkg::ST_I) ? rk_eff[tw] : RBITS'(NUM_WAYS);
      for (int k = 0; k < NUM_WAYS; k++) begin
        if (WBITS'(k) != tw && st_eff[k] != scc_pkg::ST_I && rk_eff[k] < r)
          rk_new[k] = rk_eff[k] + 1'b1;
      end
      rk_new[tw] = '0;
      st_new[tw] = res.line_state;
      tag_new[tw] = tag_q;
    end else begin
      r = rk_eff[hw];
      if (hit) begin
        st_new[hw] = res.line_state;
        if (res.did_invalidation) begin
          for (int k = 0; k < NUM_WAYS; k++) begin
            if (WBITS'(k) != hw && st_eff[k] != scc_pkg::ST_I && rk_eff[k] > r)
              rk_new[k] = rk_eff[k] - 1'b1;
          end
          rk_new[hw] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      tag_rd_q <= tag_mem[set_idx];
      st_rd_q  <= st_mem[set_idx];
      rk_rd_q  <= rk_mem[set_idx];
      req_q    <= req_i;
    end
    if (ctl_i.update) begin
      tag_mem[set_q_idx] <= tag_new;
      st_mem[set_q_idx]  <= st_new;
      rk_mem[set_q_idx]  <= rk_new;
      rsp_q <= res;
    end
  end

  // per-set valid: an unwritten set reads as all invalid, rank zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (ctl_i.load) rd_vld_q <= set_vld_q[set_idx];
      if (ctl_i.update) set_vld_q[set_q_idx] <= 1'b1;
    end
  end

  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

>>> design/scc_ctrl.sv
// Handshake sequencer: read set, update set, hold result.
`timescale 1ns / 1ps
`default_nettype none
module scc_ctrl (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   req_valid_i,
  output logic        req_ready_o,
  output logic        rsp_valid_o,
  input  wire logic   rsp_ready_i,
  output scc_pkg::ctl_t ctl_o
);
  typedef enum logic [1:0] {IDLE, UPD, OUT} state_e;
  state_e state_q;

  always_comb begin
    req_ready_o = (state_q == IDLE) || (state_q == OUT && rsp_ready_i);
    rsp_valid_o = (state_q == OUT);
    ctl_o.load = req_valid_i && req_ready_o;
    ctl_o.update = (state_q == UPD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      unique case (state_q)
        IDLE: if (req_valid_i) state_q <= UPD;
        UPD: state_q <= OUT;
        OUT: if (rsp_ready_i) state_q <= req_valid_i ? UPD : IDLE;
        default: state_q <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/snooping_coherent_cache_controller.sv
// Top level of the snooping coherent cache controller.
`timescale 1ns / 1ps
`default_nettype none
// MSI/MESI/Dragon tag, state and LRU store, set-associative. A request is
// taken together with a read of its set; in the UPD state that follows, the
// whole set is read-modify-written and the output register is loaded, and
// the result is then held valid in OUT. A new request is taken in the cycle
// its predecessor's result is taken, so only one transaction is in flight
// at a time; a stalled consumer holds off new requests. cfg writes
// (protocol_mode) are always taken and apply from the next update cycle, so
// write them only while no transaction is in flight.
module snooping_coherent_cache_controller #(
  parameter int unsigned NUM_SETS    = 16,
  parameter int unsigned NUM_WAYS    = 8,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_data_i,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire scc_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output scc_pkg::rsp_t      rsp_o
);
  logic [1:0] mode_q;
  scc_pkg::ctl_t ctl;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= scc_pkg::MODE_MSI;
    else if (cfg_valid_i) mode_q <= cfg_data_i;
  end

  scc_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i,
    .ctl_o(ctl)
  );

  scc_datapath #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
    .BLOCK_BYTES(BLOCK_BYTES), .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .req_i, .mode_i(mode_q), .rsp_o
  );
endmodule
`default_nettype wire

>>> test/testbench.sv
// Testbench for the snooping coherent cache controller: directed and random coherence traffic.
`timescale 1ns / 1ps
module testbench;

  localparam int SETS = 16;
  localparam int WAYS = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_data_i;
  logic req_valid_i;
  logic req_ready_o;
  scc_pkg::req_t req_i;
  logic rsp_valid_o;
  logic rsp_ready_i;
  scc_pkg::rsp_t rsp_o;

  snooping_coherent_cache_controller uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .req_valid_i(req_valid_i), .req_ready_o(req_ready_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o)
  );

  // shadow copy of the cache directory
  logic [21:0] shadow_tag[SETS*WAYS];
  logic [2:0] shadow_state[SETS*WAYS];
  int unsigned shadow_rank[SETS*WAYS];
  logic [1:0] shadow_mode;

  scc_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  int idle_pct = 25;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // make way w most recent; invalid ways count as oldest
  function automatic void promote(int base, int w);
    int unsigned r;
    r = (shadow_state[base+w] != scc_pkg::ST_I) ? shadow_rank[base+w] : WAYS;
    for (int k = 0; k < WAYS; k++)
      if (k != w && shadow_state[base+k] != scc_pkg::ST_I && shadow_rank[base+k] < r)
        shadow_rank[base+k]++;
    shadow_rank[base+w] = 0;
  endfunction

  function automatic void evict_line(int base, int w);
    int unsigned r;
    r = shadow_rank[base+w];
    for (int k = 0; k < WAYS; k++)
      if (k != w && shadow_state[base+k] != scc_pkg::ST_I && shadow_rank[base+k] > r)
        shadow_rank[base+k]--;
    shadow_state[base+w] = scc_pkg::ST_I;
    shadow_rank[base+w] = 0;
  endfunction

  function automatic scc_pkg::rsp_t coherence_step(scc_pkg::req_t rq);
    scc_pkg::rsp_t o;
    logic [1:0] md;
    logic [21:0] tg;
    logic [2:0] st, vs;
    int base, w, v;
    int unsigned best;
    logic wr, oc, dirty;
    o = '0;
    md = (shadow_mode == scc_pkg::MODE_RSVD) ? scc_pkg::MODE_MSI : shadow_mode;
    tg = rq.addr[31:10];
    base = int'(rq.addr[9:6]) * WAYS;
    oc = rq.other_copies;
    w = WAYS;
    for (int k = WAYS - 1; k >= 0; k--)
      if (shadow_state[base+k] != scc_pkg::ST_I && shadow_tag[base+k] == tg) w = k;
    if (rq.req_type == scc_pkg::REQ_PRD || rq.req_type == scc_pkg::REQ_PWR) begin
      wr = rq.req_type == scc_pkg::REQ_PWR;
      if (w == WAYS) begin
        v = WAYS;
        for (int k = WAYS - 1; k >= 0; k--)
          if (shadow_state[base+k] == scc_pkg::ST_I) v = k;
        if (v == WAYS) begin
          best = 0; v = 0;
          for (int k = 0; k < WAYS; k++)
            if (shadow_rank[base+k] >= best) begin best = shadow_rank[base+k]; v = k; end
        end
        vs = shadow_state[base+v];
        dirty = vs == scc_pkg::ST_M || (md == scc_pkg::MODE_DRAGON && vs == scc_pkg::ST_SM);
        o.mem_transactions = 2'd1;
        if (md == scc_pkg::MODE_MESI && oc) begin
          o.mem_transactions = 2'd0; o.cache_transfer = 1'b1;
        end
        if (dirty) begin o.did_writeback = 1'b1; o.mem_transactions++; end
        promote(base, v);
        shadow_tag[base+v] = tg;
        if (md == scc_pkg::MODE_MSI) begin
          st = wr ? scc_pkg::ST_M : scc_pkg::ST_S;
          o.issue_bus_rdx = wr; o.issue_bus_rd = !wr;
        end else if (md == scc_pkg::MODE_MESI) begin
          st = wr ? scc_pkg::ST_M : (oc ? scc_pkg::ST_S : scc_pkg::ST_E);
          o.issue_bus_rdx = wr; o.issue_bus_rd = !wr;
        end else begin
          o.issue_bus_rd = 1'b1;
          if (oc) begin
            st = wr ? scc_pkg::ST_SM : scc_pkg::ST_SC; o.issue_bus_update = wr;
          end else st = wr ? scc_pkg::ST_M : scc_pkg::ST_E;
        end
        shadow_state[base+v] = st;
      end else begin
        st = shadow_state[base+w];
        o.hit = 1'b1;
        promote(base, w);
        if (wr) begin
          if (md == scc_pkg::MODE_MSI) begin
            if (st == scc_pkg::ST_S) begin
              st = scc_pkg::ST_M; o.issue_bus_rdx = 1'b1; o.mem_transactions = 2'd1;
            end
          end else if (md == scc_pkg::MODE_MESI) begin
            if (st == scc_pkg::ST_E) st = scc_pkg::ST_M;
            else if (st == scc_pkg::ST_S) begin
              st = scc_pkg::ST_M; o.issue_bus_upgr = 1'b1;
            end
          end else if (st == scc_pkg::ST_E) st = scc_pkg::ST_M;
          else if (st == scc_pkg::ST_SC || st == scc_pkg::ST_SM) begin
            st = oc ? scc_pkg::ST_SM : scc_pkg::ST_M; o.issue_bus_update = 1'b1;
          end
        end
        shadow_state[base+w] = st;
      end
      o.line_state = st;
    end else if (w != WAYS) begin
      st = shadow_state[base+w];
      o.hit = 1'b1;
      if (rq.req_type == scc_pkg::REQ_BRD) begin
        if (md == scc_pkg::MODE_DRAGON) begin
          if (st == scc_pkg::ST_M) begin st = scc_pkg::ST_SM; o.did_intervention = 1'b1; end
          if (st == scc_pkg::ST_E) begin st = scc_pkg::ST_SC; o.did_intervention = 1'b1; end
          if (st == scc_pkg::ST_SM) o.did_flush = 1'b1;
        end else begin
          if (st == scc_pkg::ST_M) begin
            st = scc_pkg::ST_S; o.did_flush = 1'b1; o.did_writeback = 1'b1;
            o.did_intervention = 1'b1; o.mem_transactions = 2'd1;
          end
          if (md == scc_pkg::MODE_MESI && st == scc_pkg::ST_E) begin
            st = scc_pkg::ST_S; o.did_intervention = 1'b1;
          end
        end
        shadow_state[base+w] = st;
      end else if (rq.req_type == scc_pkg::REQ_BRDX && md != scc_pkg::MODE_DRAGON) begin
        if (st == scc_pkg::ST_M) begin
          o.did_flush = 1'b1; o.did_writeback = 1'b1; o.mem_transactions = 2'd1;
        end
        if (md == scc_pkg::MODE_MSI || st == scc_pkg::ST_M || st == scc_pkg::ST_S ||
            st == scc_pkg::ST_E) begin
          evict_line(base, w); o.did_invalidation = 1'b1; st = scc_pkg::ST_I;
        end
      end else if (rq.req_type == scc_pkg::REQ_BUPGR && md == scc_pkg::MODE_MESI) begin
        if (st == scc_pkg::ST_S) begin
          evict_line(base, w); o.did_invalidation = 1'b1; st = scc_pkg::ST_I;
        end
      end else if (rq.req_type == scc_pkg::REQ_BUPD && md == scc_pkg::MODE_DRAGON) begin
        if (st == scc_pkg::ST_SM) begin st = scc_pkg::ST_SC; shadow_state[base+w] = st; end
      end
      o.line_state = st;
    end
    return o;
  endfunction

  // response side: random stall and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response %h", $time, rsp_o);
          errors++;
        end else begin
          if (rsp_o !== expected_rsps[0]) begin
            $display("%0t: mismatch expected %p actual %p", $time, expected_rsps[0], rsp_o);
            errors++;
          end
          void'(expected_rsps.pop_front());
        end
      end
      rsp_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays up across back-to-back transactions; it drops only while idling
  task automatic send_req(logic [2:0] rt, logic [31:0] a, logic oc);
    scc_pkg::req_t rq;
    while ($urandom_range(99) < idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rq.req_type = rt; rq.addr = a; rq.other_copies = oc;
    req_valid_i <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    expected_rsps.push_back(coherence_step(rq));
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_protocol(logic [1:0] md);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= md;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow_mode = md;
    cfg_valid_i <= 1'b0;
  endtask

  // a few tags per set so lines conflict, hit and get evicted
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom();
    if ($urandom_range(9) != 0) a[31:10] = 22'($urandom_range(11));
    if ($urandom_range(3) != 0) a[9:6] = 4'($urandom_range(2));
    return a;
  endfunction

  task automatic test_directed();
    for (int m = 0; m < 3; m++) begin
      set_protocol(m[1:0]);
      send_req(scc_pkg::REQ_BRD, 32'hFFFF_FFFF, 1'b1);
      send_req(scc_pkg::REQ_PRD, 32'h0000_0000, 1'b0);
      send_req(scc_pkg::REQ_PWR, 32'h0000_0000, 1'b1);
      send_req(scc_pkg::REQ_BRD, 32'h0000_0000, 1'b0);
      send_req(scc_pkg::REQ_BUPD, 32'h0000_0000, 1'b0);
      send_req(scc_pkg::REQ_PWR, 32'hFFFF_FFFF, 1'b0);
      send_req(scc_pkg::REQ_BRDX, 32'hFFFF_FFFF, 1'b1);
      send_req(scc_pkg::REQ_BUPGR, 32'h0000_0000, 1'b0);
      send_req(scc_pkg::REQ_RSV6, 32'h0000_0000, 1'b0);
      send_req(scc_pkg::REQ_RSV7, 32'hFFFF_FFFF, 1'b1);
    end
  endtask

  // fill one set past its ways to force LRU eviction of dirty lines
  task automatic test_eviction();
    set_protocol(scc_pkg::MODE_DRAGON);
    for (int i = 0; i < 12; i++) send_req(scc_pkg::REQ_PWR, {22'(i), 4'd5, 6'd0}, i[0]);
  endtask

  task automatic test_random(int n);
    logic [2:0] rt;
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 0) set_protocol(2'($urandom_range(3)));
      idle_pct = (i % 600 < 150) ? 0 : 25;
      if (i == n / 2) drain();
      rt = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      send_req(rt, pick_addr(), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    for (int k = 0; k < SETS*WAYS; k++) begin
      shadow_tag[k] = '0; shadow_state[k] = scc_pkg::ST_I; shadow_rank[k] = 0;
    end
    shadow_mode = scc_pkg::MODE_MSI;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    req_valid_i = 1'b0;
    req_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_eviction();
    set_protocol(scc_pkg::MODE_RSVD);
    test_random(1800);
    drain();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
